>>> rtl/phl_pkg.sv
// PS/2 host link package: field widths, frame and prefix constants,
// input and result codes, and the result payload struct.
// No dependencies; compile first.
`default_nettype none

package phl_pkg;

   localparam int unsigned IDLE_W = 16;
   localparam int unsigned CNT_W  = 4;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned FUNC_W = 2;
   localparam int unsigned KIND_W = 2;

   localparam logic [IDLE_W-1:0] IDLE_RESET = 16'd250;
   localparam logic [IDLE_W-1:0] IDLE_MAX   = 16'hFFFF;

   // prefix bytes of the scan code set
   localparam logic [BYTE_W-1:0] CODE_UP    = 8'hF0;
   localparam logic [BYTE_W-1:0] CODE_EXT0  = 8'hE0;
   localparam logic [BYTE_W-1:0] CODE_EXT1  = 8'hE1;
   localparam logic [BYTE_W-1:0] CODE_PAUSE = 8'h14;

   // edge numbers within a frame, counted from 1
   localparam logic [CNT_W-1:0] FIRST_DATA  = 4'd2;
   localparam logic [CNT_W-1:0] LAST_DATA   = 4'd9;
   localparam logic [CNT_W-1:0] PARITY_EDGE = 4'd10;
   localparam logic [CNT_W-1:0] FRAME_BITS  = 4'd11;
   localparam logic [CNT_W-1:0] SEND_EDGES  = 4'd12;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_EDGE = 2'd0,
      FUNC_SEND = 2'd1,
      FUNC_TICK = 2'd2
   } func_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_DRIVE     = 2'd0,
      KIND_CODE      = 2'd1,
      KIND_SEND_DONE = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic              drive_level;
      logic              drive_enable;
      logic [BYTE_W-1:0] scan_code;
      logic              ext0_flag;
      logic              ext1_flag;
      logic              key_up_flag;
      logic              parity_fault;
      logic              ack_bit;
   } rsp_payload_type;

endpackage

`default_nettype wire

>>> rtl/phl_req_if.sv
// Request channel of the PS/2 host link: valid/ready and the item fields.
// Depends on phl_pkg.
`default_nettype none

interface phl_req_if;
   import phl_pkg::*;

   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic              data_line;
   logic [BYTE_W-1:0] send_byte;

   modport source (output valid, func, data_line, send_byte, input ready);
   modport sink   (input valid, func, data_line, send_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/phl_rsp_if.sv
// Result channel of the PS/2 host link: valid/ready and the result fields.
// Depends on phl_pkg.
`default_nettype none

interface phl_rsp_if;
   import phl_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic              drive_level;
   logic              drive_enable;
   logic [BYTE_W-1:0] scan_code;
   logic              ext0_flag;
   logic              ext1_flag;
   logic              key_up_flag;
   logic              parity_fault;
   logic              ack_bit;

   modport source (output valid, kind, drive_level, drive_enable, scan_code, ext0_flag,
                   ext1_flag, key_up_flag, parity_fault, ack_bit, input ready);
   modport sink   (input valid, kind, drive_level, drive_enable, scan_code, ext0_flag,
                   ext1_flag, key_up_flag, parity_fault, ack_bit, output ready);
endinterface

`default_nettype wire

>>> rtl/ps2_host_link_with_scan_decode_core.sv
// PS/2 host link core: receive framing, prefix decoding, send framing,
// result register with skid stage.
// Depends on phl_pkg, phl_req_if and phl_rsp_if.
//
//   channel | direction | handshake                  | beat
//   --------+-----------+----------------------------+-------------------------------
//   req_ch  | in        | valid/ready                | clock edge, send request, tick
//   rsp_ch  | out       | valid/ready                | line drive, scan code, send done
//   csr     | in        | csr_write_enable, no wait  | idle timeout in ms (16 bits)
//
// One beat per cycle while req_ch.ready is high: each beat updates the link
// state in the cycle it is accepted, and its result (if any) is registered for rsp_ch.
// Results sit in an output register backed by a one-entry skid register;
// req_ch.ready drops only while the skid register is full.
// Reset (synchronous, active high) clears all link state, loads the idle
// timeout with 250 and empties both result registers.
`default_nettype none

module ps2_host_link_with_scan_decode_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_write_enable,
   input  wire logic [phl_pkg::IDLE_W-1:0]  csr_write_data,
   phl_req_if.sink                          req_ch,
   phl_rsp_if.source                        rsp_ch
);
   import phl_pkg::*;

   // configuration
   logic [IDLE_W-1:0] idle_timeout_ff;

   // link state
   logic              sending_ff,       sending_in;
   logic [CNT_W-1:0]  rx_bit_count_ff,  rx_bit_count_in;
   logic [BYTE_W-1:0] rx_shift_ff,      rx_shift_in;
   logic              rx_parity_acc_ff, rx_parity_acc_in;
   logic              rx_parity_bad_ff, rx_parity_bad_in;
   logic [IDLE_W-1:0] idle_ms_ff,       idle_ms_in;
   logic [CNT_W-1:0]  tx_bit_count_ff,  tx_bit_count_in;
   logic [BYTE_W-1:0] tx_shift_ff,      tx_shift_in;
   logic              tx_parity_acc_ff, tx_parity_acc_in;
   logic              pending_up_ff,    pending_up_in;
   logic              pending_ext0_ff,  pending_ext0_in;
   logic              pending_ext1_ff,  pending_ext1_in;

   // result buffering
   logic              out_valid_ff,  out_valid_in;
   rsp_payload_type   out_data_ff,   out_data_in;
   logic              skid_valid_ff, skid_valid_in;
   rsp_payload_type   skid_data_ff,  skid_data_in;

   // per-beat working values
   func_type          req_func;
   logic              accept;
   logic              pop;
   logic              res_valid;
   rsp_payload_type   res_data;
   logic              rx_restart;
   logic [CNT_W-1:0]  rx_count_base;
   logic [CNT_W-1:0]  rx_count_next;
   logic [BYTE_W-1:0] rx_shift_base;
   logic [BYTE_W-1:0] rx_shift_take;
   logic              rx_acc_base;
   logic [CNT_W-1:0]  tx_count_next;

   assign req_func = func_type'(req_ch.func);
   assign accept   = req_ch.valid && req_ch.ready;
   assign pop      = out_valid_ff && rsp_ch.ready;

   // take a new beat unless the skid register is occupied
   assign req_ch.ready = !skid_valid_ff;

   // drop a stalled partial frame when the gap since the last edge is too long
   assign rx_restart    = idle_ms_ff > idle_timeout_ff;
   assign rx_count_base = rx_restart ? '0 : rx_bit_count_ff;
   assign rx_count_next = rx_count_base + CNT_W'(1);
   assign rx_shift_base = rx_restart ? '0 : rx_shift_ff;
   assign rx_acc_base   = rx_restart ? 1'b1 : rx_parity_acc_ff;
   // data arrives LSB first: shift in from the top
   assign rx_shift_take = {req_ch.data_line, rx_shift_base[BYTE_W-1:1]};

   assign tx_count_next = tx_bit_count_ff + CNT_W'(1);

   // link state update and result for the accepted beat
   always_comb begin
      sending_in       = sending_ff;
      rx_bit_count_in  = rx_bit_count_ff;
      rx_shift_in      = rx_shift_ff;
      rx_parity_acc_in = rx_parity_acc_ff;
      rx_parity_bad_in = rx_parity_bad_ff;
      idle_ms_in       = idle_ms_ff;
      tx_bit_count_in  = tx_bit_count_ff;
      tx_shift_in      = tx_shift_ff;
      tx_parity_acc_in = tx_parity_acc_ff;
      pending_up_in    = pending_up_ff;
      pending_ext0_in  = pending_ext0_ff;
      pending_ext1_in  = pending_ext1_ff;
      res_valid        = 1'b0;
      res_data         = '0;

      if (accept) begin
         unique case (req_func)
            FUNC_EDGE: begin
               if (sending_ff) begin
                  // send mode: every edge answers with a line drive or the ack
                  res_valid       = 1'b1;
                  tx_bit_count_in = tx_count_next;
                  if (tx_count_next >= SEND_EDGES) begin
                     // release the line and report the device's ack level
                     res_data.kind    = KIND_SEND_DONE;
                     res_data.ack_bit = req_ch.data_line;
                     tx_bit_count_in  = '0;
                     tx_shift_in      = '0;
                     tx_parity_acc_in = 1'b1;
                     sending_in       = 1'b0;
                  end else begin
                     res_data.kind         = KIND_DRIVE;
                     res_data.drive_enable = 1'b1;
                     priority if (tx_count_next >= FIRST_DATA &&
                                  tx_count_next <= LAST_DATA) begin
                        res_data.drive_level = tx_shift_ff[0];
                        tx_shift_in      = {tx_shift_ff[0], tx_shift_ff[BYTE_W-1:1]};
                        tx_parity_acc_in = tx_parity_acc_ff ^ tx_shift_ff[0];
                     end else if (tx_count_next == PARITY_EDGE) begin
                        res_data.drive_level = tx_parity_acc_ff;
                     end else if (tx_count_next == FRAME_BITS) begin
                        res_data.drive_level = 1'b1;
                     end else begin
                        res_data.drive_level = 1'b0;
                     end
                  end
               end else begin
                  // receive mode
                  idle_ms_in       = '0;
                  rx_bit_count_in  = rx_count_next;
                  rx_shift_in      = rx_shift_base;
                  rx_parity_acc_in = rx_acc_base;
                  if (rx_count_next <= LAST_DATA) begin
                     rx_shift_in = rx_shift_take;
                     if (rx_count_next >= FIRST_DATA) begin
                        rx_parity_acc_in = rx_acc_base ^ req_ch.data_line;
                     end
                  end
                  if (rx_count_next == PARITY_EDGE) begin
                     rx_parity_bad_in = rx_acc_base != req_ch.data_line;
                  end
                  if (rx_count_next >= FRAME_BITS) begin
                     rx_bit_count_in  = '0;
                     rx_shift_in      = '0;
                     rx_parity_acc_in = 1'b1;
                     // prefixes are held for the next code
                     priority if (rx_shift_base == CODE_UP) begin
                        pending_up_in = 1'b1;
                     end else if (rx_shift_base == CODE_EXT0) begin
                        pending_ext0_in = 1'b1;
                     end else if (rx_shift_base == CODE_EXT1) begin
                        pending_ext1_in = 1'b1;
                     end else begin
                        res_valid             = 1'b1;
                        res_data.kind         = KIND_CODE;
                        res_data.scan_code    = rx_shift_base;
                        res_data.ext0_flag    = pending_ext0_ff;
                        res_data.ext1_flag    = pending_ext1_ff;
                        res_data.key_up_flag  = pending_up_ff;
                        res_data.parity_fault = rx_parity_bad_ff;
                        pending_up_in         = 1'b0;
                        pending_ext0_in       = 1'b0;
                        // Pause sequence: keep ext1 across its 0x14 code
                        pending_ext1_in = pending_ext1_ff && (rx_shift_base == CODE_PAUSE);
                     end
                  end
               end
            end
            FUNC_SEND: begin
               // ignore a send request while a send is in flight
               if (!sending_ff) begin
                  sending_in       = 1'b1;
                  tx_shift_in      = req_ch.send_byte;
                  tx_bit_count_in  = '0;
                  tx_parity_acc_in = 1'b1;
               end
            end
            FUNC_TICK: begin
               if (idle_ms_ff != IDLE_MAX) begin
                  idle_ms_in = idle_ms_ff + IDLE_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // output register with skid stage behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            // advance the held beat; no new result can arrive while skid is full
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = res_valid;
            if (res_valid) begin
               out_data_in = res_data;
            end
         end
      end else if (res_valid) begin
         // output stalled: park the new result
         skid_valid_in = 1'b1;
         skid_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_timeout_ff  <= IDLE_RESET;
         sending_ff       <= 1'b0;
         rx_bit_count_ff  <= '0;
         rx_shift_ff      <= '0;
         rx_parity_acc_ff <= 1'b1;
         rx_parity_bad_ff <= 1'b0;
         idle_ms_ff       <= '0;
         tx_bit_count_ff  <= '0;
         tx_shift_ff      <= '0;
         tx_parity_acc_ff <= 1'b1;
         pending_up_ff    <= 1'b0;
         pending_ext0_ff  <= 1'b0;
         pending_ext1_ff  <= 1'b0;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            idle_timeout_ff <= csr_write_data;
         end
         sending_ff       <= sending_in;
         rx_bit_count_ff  <= rx_bit_count_in;
         rx_shift_ff      <= rx_shift_in;
         rx_parity_acc_ff <= rx_parity_acc_in;
         rx_parity_bad_ff <= rx_parity_bad_in;
         idle_ms_ff       <= idle_ms_in;
         tx_bit_count_ff  <= tx_bit_count_in;
         tx_shift_ff      <= tx_shift_in;
         tx_parity_acc_ff <= tx_parity_acc_in;
         pending_up_ff    <= pending_up_in;
         pending_ext0_ff  <= pending_ext0_in;
         pending_ext1_ff  <= pending_ext1_in;
         out_valid_ff     <= out_valid_in;
         skid_valid_ff    <= skid_valid_in;
      end
   end

   // result payload registers carry no reset
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.kind         = out_data_ff.kind;
   assign rsp_ch.drive_level  = out_data_ff.drive_level;
   assign rsp_ch.drive_enable = out_data_ff.drive_enable;
   assign rsp_ch.scan_code    = out_data_ff.scan_code;
   assign rsp_ch.ext0_flag    = out_data_ff.ext0_flag;
   assign rsp_ch.ext1_flag    = out_data_ff.ext1_flag;
   assign rsp_ch.key_up_flag  = out_data_ff.key_up_flag;
   assign rsp_ch.parity_fault = out_data_ff.parity_fault;
   assign rsp_ch.ack_bit      = out_data_ff.ack_bit;

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output register empty");

   a_tx_idle_count: assert property (@(posedge clock) disable iff (reset)
      !sending_ff |-> (tx_bit_count_ff == '0))
      else $error("send edge count nonzero outside send mode");

   a_rx_count_range: assert property (@(posedge clock) disable iff (reset)
      rx_bit_count_ff <= PARITY_EDGE)
      else $error("receive edge count past parity edge");

   a_send_done_ends: assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == FUNC_EDGE && sending_ff && tx_count_next == SEND_EDGES)
      |=> (!sending_ff && out_valid_ff))
      else $error("ack edge did not end send mode with a result");

   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      (accept && res_valid) |=> out_valid_ff)
      else $error("result of accepted beat not held");
`endif

endmodule

`default_nettype wire
